### rtl/mwerms_pkg.sv
// ----------------------------------------------------------------------------
// mwerms_pkg
// Shared types and constants for the moving-window energy and rms block.
// ----------------------------------------------------------------------------
package mwerms_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int POWER_W     = 2 * SAMPLE_BITS;
    localparam int ENERGY_W    = 42;
    localparam int RMS_W       = 16;
    localparam int WL_W        = 11;
    localparam int ROOT_W      = ENERGY_W / 2;

    // Register word indexes on the configuration port
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // Sample transaction payload
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
        logic                          block_start;
    } sample_t;

    // Result transaction payload
    typedef struct packed {
        logic [ENERGY_W-1:0] window_energy;
        logic [RMS_W-1:0]    window_rms;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

### rtl/mwerms_ram.sv
// ----------------------------------------------------------------------------
// mwerms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mwerms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/mwerms_div.sv
// ----------------------------------------------------------------------------
// mwerms_div
// Restoring divider, one quotient bit per cycle: energy over window length.
// ----------------------------------------------------------------------------
module mwerms_div
    import mwerms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ENERGY_W-1:0] dividend,
    input  logic [WL_W-1:0]     divisor,
    output logic                done,
    output logic [ENERGY_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ENERGY_W);

    logic [ENERGY_W-1:0] quo_reg, quo_next;
    logic [WL_W-1:0]     rem_reg, rem_next;
    logic [WL_W-1:0]     dvs_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [WL_W:0]       trial;
    logic [WL_W:0]       diff;

    // One shift-and-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[ENERGY_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[WL_W-1:0];
                quo_next = {quo_reg[ENERGY_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WL_W-1:0];
                quo_next = {quo_reg[ENERGY_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ENERGY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/mwerms_sqrt.sv
// ----------------------------------------------------------------------------
// mwerms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module mwerms_sqrt
    import mwerms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ENERGY_W-1:0] radicand,
    output logic                done,
    output logic [RMS_W-1:0]    root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic [ENERGY_W-1:0] x_reg, x_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [REM_W-1:0]    trial_rem;
    logic [REM_W-1:0]    trial;

    // One root bit per step: bring down two radicand bits and try a 1
    always_comb
    begin
        trial_rem = {rem_reg[REM_W-3:0], x_reg[ENERGY_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[ENERGY_W-3:0], 2'b00};
            if (trial_rem >= trial)
            begin
                rem_next  = trial_rem - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial_rem;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg[RMS_W-1:0];

endmodule

### rtl/moving_window_energy_rms.sv
// ----------------------------------------------------------------------------
// moving_window_energy_rms
// Moving-window energy and rms of a complex I/Q sample stream.
// ----------------------------------------------------------------------------
// Each sample transaction passes the ring read and update; while the window
// is not yet full, no result follows. Once the window is full, the sample
// also runs through the bit-serial divider, the bit-serial square root and
// the load of the result register, and no new sample is taken before that
// load. The divider and square root set the sample rate. Loading waits for
// as long as an earlier result is still held and stalled.
// The power ring lives in one RAM; the slot that leaves the window is read
// when the sample is taken and the new power is written back the next cycle.
// A writing of window_length clears the fill count and the running sum.
// ----------------------------------------------------------------------------
module moving_window_energy_rms
    import mwerms_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // Sample channel
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    // Result channel
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    state_t state_reg, state_next;

    logic [WL_W-1:0]     wl_reg;
    logic [WL_W-1:0]     w_eff;
    logic [ENERGY_W-1:0] sum_reg, sum_next;
    logic [WL_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                bs_reg;
    logic [POWER_W-1:0]  sq_i_reg, sq_q_reg;
    logic signed [POWER_W-1:0] prod_i, prod_q;

    logic [PTR_W:0]      old_wide;
    logic [PTR_W-1:0]    old_addr;
    logic [POWER_W-1:0]  ring_rdata;
    logic                ring_we;
    logic [POWER_W-1:0]  power;

    logic [WL_W-1:0]     fill_eff;
    logic [ENERGY_W-1:0] base_sum;
    logic [ENERGY_W-1:0] leaving;
    logic                window_full;

    logic                cfg_write;
    logic                sample_take;
    logic                result_take;
    logic                out_free;
    logic                div_start, div_done;
    logic [ENERGY_W-1:0] quotient;
    logic                sqrt_done;
    logic [RMS_W-1:0]    root;
    logic                load_result;

    result_t             result_reg;
    logic                result_valid_reg, result_valid_next;

    // Effective window length: zero counts as one, clamp to the ring depth
    always_comb
    begin
        if (wl_reg == '0)
        begin
            w_eff = WL_W'(1);
        end
        else if (32'(wl_reg) > 32'(MAX_WINDOW))
        begin
            w_eff = WL_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = wl_reg;
        end
    end

    assign cfg_write   = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
    assign sample_take = sample_valid && !sample_stall;
    assign result_take = result_valid_reg && !result_stall;
    assign out_free    = !result_valid_reg || !result_stall;

    // Ring slot that drops out of the window
    assign old_wide = {1'b0, ptr_reg} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(w_eff);
    always_comb
    begin
        if (old_wide >= (PTR_W+1)'(MAX_WINDOW))
        begin
            old_addr = PTR_W'(old_wide - (PTR_W+1)'(MAX_WINDOW));
        end
        else
        begin
            old_addr = old_wide[PTR_W-1:0];
        end
    end

    // Squares of the incoming sample
    assign prod_i = sample.sample_i * sample.sample_i;
    assign prod_q = sample.sample_q * sample.sample_q;

    // Sum update once the leaving power is back from the ring
    assign power       = sq_i_reg + sq_q_reg;
    assign fill_eff    = bs_reg ? '0 : fill_reg;
    assign base_sum    = bs_reg ? '0 : sum_reg;
    assign leaving     = (fill_eff >= w_eff) ? ENERGY_W'(ring_rdata) : '0;
    assign ring_we     = (state_reg == ST_READ);

    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (cfg_write)
        begin
            sum_next  = '0;
            fill_next = '0;
        end
        else if (state_reg == ST_READ)
        begin
            sum_next  = base_sum - leaving + ENERGY_W'(power);
            fill_next = (fill_eff < w_eff) ? fill_eff + 1'b1 : fill_eff;
            if (32'(ptr_reg) == MAX_WINDOW - 1)
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    assign window_full = (fill_next >= w_eff);
    assign div_start   = (state_reg == ST_READ) && window_full;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = window_full ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        sample_stall = 1'b1;
        load_result  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
            end
            ST_OUT:
            begin
                load_result = out_free;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    // Result register valid flag
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wl_reg           <= WL_W'(1);
            sum_reg          <= '0;
            fill_reg         <= '0;
            ptr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            fill_reg         <= fill_next;
            ptr_reg          <= ptr_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                wl_reg <= pwdata[WL_W-1:0];
            end
        end
    end

    // Sample and result payload registers
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            sq_i_reg <= POWER_W'($unsigned(prod_i));
            sq_q_reg <= POWER_W'($unsigned(prod_q));
            bs_reg   <= sample.block_start;
        end
        if (load_result)
        begin
            result_reg.window_energy <= sum_reg;
            result_reg.window_rms    <= root;
        end
    end

    // Power ring
    mwerms_ram #(
        .WIDTH (POWER_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ptr_reg),
        .wdata (power),
        .raddr (old_addr),
        .rdata (ring_rdata)
    );

    // Energy over window length
    mwerms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    // Square root of the quotient
    mwerms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_done),
        .radicand (quotient),
        .done     (sqrt_done),
        .root     (root)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign prdata       = 32'(wl_reg);
    assign pready       = 1'b1;

    // A sample transaction is only taken by an idle sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |-> (state_reg == ST_IDLE))
        else $error("sample taken while busy");

    // The fill count never passes the window after an update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (fill_reg <= w_eff))
        else $error("fill count beyond window");

    // A new result appears only after the square root finished
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result without completed computation");

    // The divider starts only on a full window
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (fill_reg == w_eff))
        else $error("divide started before window full");

endmodule

### sim/moving_window_energy_rms_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_window_energy_rms_test
// Self-checking bench for the moving-window energy and rms block.
// ----------------------------------------------------------------------------
// A queue of sample transactions is filled per phase; each but the first
// sets the window length over the configuration port, then streams samples
// in bursts. A predictor tracks the power ring, running sum and fill count
// and queues the expected energy and rms for each accepted sample on a full
// window. A monitor compares each result against the oldest expected one.
// ----------------------------------------------------------------------------
module moving_window_energy_rms_test;
    import mwerms_pkg::*;

    localparam int MAX_WIN    = 1024;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    moving_window_energy_rms dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predictor state
    logic [POWER_W-1:0]  power_hist [MAX_WIN];
    logic [ENERGY_W-1:0] energy_acc;
    int unsigned         samples_in_block;
    int unsigned         hist_ptr;
    int unsigned         win_len;

    sample_t pending_samples [$];
    result_t expected_results [$];
    int      error_count;
    int      result_count;
    int      sample_count;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    int      stall_mode;
    bit      stream_on;
    bit      sample_taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[15:0];
    endfunction

    // Effective window length for a raw register value.
    function automatic int unsigned clamp_window(input int unsigned raw);
        if (raw == 0) return 1;
        if (raw > MAX_WIN) return MAX_WIN;
        return raw;
    endfunction

    // Advance the energy predictor by one accepted sample.
    task automatic predict_energy(input sample_t s);
        logic signed [31:0]  ii;
        logic signed [31:0]  qq;
        logic [POWER_W-1:0]  pwr;
        result_t             r;
        ii  = s.sample_i * s.sample_i;
        qq  = s.sample_q * s.sample_q;
        pwr = ii + qq;
        if (s.block_start)
        begin
            samples_in_block = 0;
            energy_acc       = 0;
        end
        if (samples_in_block >= win_len)
            energy_acc = energy_acc - power_hist[(hist_ptr + MAX_WIN - win_len) % MAX_WIN];
        power_hist[hist_ptr] = pwr;
        energy_acc = energy_acc + pwr;
        hist_ptr = (hist_ptr + 1) % MAX_WIN;
        if (samples_in_block < win_len) samples_in_block++;
        if (samples_in_block >= win_len)
        begin
            r.window_energy = energy_acc;
            r.window_rms    = root_floor(64'(energy_acc) / win_len);
            expected_results.push_back(r);
        end
    endtask

    // Register write: setup then access cycle.
    task automatic write_window(input int unsigned raw);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_WINDOW_LENGTH);
        pwdata  <= 32'(raw);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        win_len          = clamp_window(raw & 11'h7FF);
        samples_in_block = 0;
        energy_acc       = 0;
    endtask

    function automatic logic signed [15:0] pick_value(input int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one block of samples; most blocks outlast the window.
    task automatic queue_block(input int n);
        sample_t s;
        int      mode;
        mode = $urandom_range(0, 5);
        for (int k = 0; k < n; k++)
        begin
            s.sample_i    = pick_value(mode < 2 ? mode : $urandom_range(0, 7));
            s.sample_q    = pick_value(mode < 2 ? mode : $urandom_range(0, 7));
            s.block_start = (k == 0) || ($urandom_range(0, 60) == 0);
            pending_samples.push_back(s);
        end
    endtask

    // Wait for the stream and every result to drain, then settle.
    task automatic drain;
        while (pending_samples.size() != 0 || stream_on) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Driver: sender in bursts with gaps. A new transaction is presented
    // only once the current one was accepted at the last rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_valid || sample_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                    stream_on    <= pending_samples.size() != 0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample       <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    stream_on    <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left--;
                end
                else
                begin
                    sample_valid <= 1'b0;
                    stream_on    <= 1'b0;
                end
            end
            // Receiver stall pattern.
            if ($urandom_range(0, 200) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 1) == 0);
                default: result_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Monitor: predict on sample acceptance, check on result acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sample_taken <= sample_valid && !sample_stall;
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (sample_valid && !sample_stall)
            begin
                predict_energy(sample);
                sample_count++;
            end
            if (result_valid && !result_stall)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h/%0d", $time,
                             result.window_energy, result.window_rms);
                    error_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (e.window_energy !== result.window_energy)
                    begin
                        $display("%0t: window_energy expected %0d actual %0d", $time,
                                 e.window_energy, result.window_energy);
                        error_count++;
                    end
                    if (e.window_rms !== result.window_rms)
                    begin
                        $display("%0t: window_rms expected %0d actual %0d", $time,
                                 e.window_rms, result.window_rms);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus phases.
    initial
    begin
        int unsigned windows [10];
        sample_t     s;
        windows = '{1, 0, 3, 100, 7, 16, 2, 10, 5, 4};
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        result_count = 0;
        sample_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        stream_on = 1'b0;
        sample_taken = 1'b0;
        energy_acc = 0;
        samples_in_block = 0;
        hist_ptr = 0;
        win_len = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset window of one, field extremes and block starts.
        for (int k = 0; k < 12; k++)
        begin
            s.sample_i    = (k % 3 == 0) ? 16'sh8000 : (k % 3 == 1) ? 16'sh7FFF : 16'sh0000;
            s.sample_q    = (k % 2 == 0) ? 16'sh8000 : 16'sh7FFF;
            s.block_start = (k % 4 == 0);
            pending_samples.push_back(s);
        end
        drain();
        // Directed: window of three with a block start before the window fills.
        write_window(3);
        for (int k = 0; k < 8; k++)
        begin
            s.sample_i    = 16'sh8000;
            s.sample_q    = 16'sh8000;
            s.block_start = (k == 1);
            pending_samples.push_back(s);
        end
        drain();

        // Random phases over a range of window lengths, zero included.
        foreach (windows[w])
        begin
            int unsigned eff;
            write_window(windows[w]);
            eff = clamp_window(windows[w] & 11'h7FF);
            if (eff > 64)
                queue_block(eff + $urandom_range(5, 15));
            else
                for (int b = 0; b < 3; b++) queue_block(eff + $urandom_range(0, 20));
            drain();
        end

        $display("Covered %0d samples and %0d results over %0d window settings.",
                 sample_count, result_count, 12);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/mwerms_pkg.sv
rtl/mwerms_ram.sv
rtl/mwerms_div.sv
rtl/mwerms_sqrt.sv
rtl/moving_window_energy_rms.sv
sim/moving_window_energy_rms_test.sv
